FILE: hw/rtl/hsv_percent_to_rgb8_unit_defines.svh
// Assertion macros shared by the HSV to RGB conversion RTL.
`ifndef HSV_PERCENT_TO_RGB8_UNIT_DEFINES_SVH
`define HSV_PERCENT_TO_RGB8_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HSVP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsvp: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HSVP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsvp: next-cycle check failed");

`endif

FILE: hw/rtl/hsvp_pkg.sv
// Types and constants for the HSV percent to 8-bit RGB converter.
package hsvp_pkg;

  localparam int unsigned HUE_W = 9;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned X60_W = 13;  // level times 60, up to 6000
  localparam int unsigned MOD_W = 6;   // hue within a sector, 0..59

  localparam int unsigned HUE_LIMIT    = 360;
  localparam int unsigned PERCENT_FULL = 100;
  localparam int unsigned SECTOR_DEG   = 60;

  // floor(p / 100) for p up to 10000: (p * 5243) >> 19
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned PROD_W       = 14;  // (100 - s) * v
  localparam int unsigned DIV100_W     = 27;

  // floor(x * 51 / 1200) = floor(((x * 17) >> 4) / 25); /25 as (z * 41944) >> 20
  localparam int unsigned SCALE_MUL    = 17;
  localparam int unsigned SCALE_PRE    = 4;
  localparam int unsigned DIV25_MUL    = 41944;
  localparam int unsigned DIV25_SHIFT  = 20;
  localparam int unsigned PRE_W        = 18;
  localparam int unsigned DIV25_W      = 29;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;
  } pixel_t;

  typedef struct packed {
    logic            valid_res;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic en;
  } stage_ctl_t;

endpackage

FILE: hw/rtl/hsv_percent_to_rgb8_unit.sv
// Top level: pipelined HSV (degrees, percent) to 8-bit RGB converter.
//
//   channel  | signals                      | carries
//   ---------+------------------------------+-----------------------------------
//   pixel    | pixel_valid, pixel_ready     | pixel_t: hue, saturation, brightness
//   rgb      | rgb_valid, rgb_ready         | rgb_t: valid_res, red, green, blue
//
// Six register stages, the last being the output register.
// One pixel enters per clock while rgb is not stalled; throughput is one transfer per cycle.
// A stall on rgb freezes every stage at once; pixel_ready follows rgb_ready
// whenever the output register is full, so nothing is dropped or repeated.
// rst clears the stage valid bits only.
`include "hsv_percent_to_rgb8_unit_defines.svh"

module hsv_percent_to_rgb8_unit
  import hsvp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_ready,
  input  pixel_t pixel,
  output logic   rgb_valid,
  input  logic   rgb_ready,
  output rgb_t   rgb
);

  localparam int unsigned STAGES = 6;

  stage_ctl_t ctl;
  logic [STAGES-1:0] vld;

  // stage 1
  logic             ok1;
  sector_t          sec1;
  logic [MOD_W-1:0] hmod1;
  logic [PCT_W-1:0] v1;
  logic [PROD_W-1:0] prod1;
  // stage 2
  logic             ok2;
  sector_t          sec2;
  logic [MOD_W-1:0] hmod2;
  logic [PCT_W-1:0] v2;
  logic [PCT_W-1:0] vmin2;
  // stage 3
  logic             ok3;
  sector_t          sec3;
  logic [X60_W-1:0] v60_3;
  logic [X60_W-1:0] vmin60_3;
  logic [X60_W-1:0] a60_3;
  // stages 4 and 5 (side band beside the scalers)
  logic             ok4, ok5;
  sector_t          sec4, sec5;

  logic             in_range;
  sector_t          sec_in;
  logic [HUE_W-1:0] sec_base;
  logic [DIV100_W-1:0] div_prod;
  logic [PCT_W-1:0] diff2;
  logic [X60_W-1:0] x_cv, x_cmin, x_cinc, x_cdec;
  logic [CH_W-1:0]  cv, cmin, cinc, cdec;
  rgb_t             rgb_next;

  assign ctl.en      = !vld[STAGES-1] || rgb_ready;
  assign pixel_ready = ctl.en;
  assign rgb_valid   = vld[STAGES-1];

  assign in_range = (pixel.hue < HUE_W'(HUE_LIMIT))
                 && (pixel.saturation <= PCT_W'(PERCENT_FULL))
                 && (pixel.brightness <= PCT_W'(PERCENT_FULL));

  always_comb begin
    if (pixel.hue >= HUE_W'(5 * SECTOR_DEG))      sec_in = SEC_5;
    else if (pixel.hue >= HUE_W'(4 * SECTOR_DEG)) sec_in = SEC_4;
    else if (pixel.hue >= HUE_W'(3 * SECTOR_DEG)) sec_in = SEC_3;
    else if (pixel.hue >= HUE_W'(2 * SECTOR_DEG)) sec_in = SEC_2;
    else if (pixel.hue >= HUE_W'(SECTOR_DEG))     sec_in = SEC_1;
    else                                          sec_in = SEC_0;
  end

  assign sec_base = HUE_W'(sec_in) * HUE_W'(SECTOR_DEG);
  assign div_prod = DIV100_W'(prod1) * DIV100_W'(DIV100_MUL);
  assign diff2    = v2 - vmin2;

  // out-of-range inputs produce garbage here; the ok bit zeroes them later
  assign x_cv   = v60_3;
  assign x_cmin = vmin60_3;
  assign x_cinc = vmin60_3 + a60_3;
  assign x_cdec = v60_3 - a60_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.en) begin
      vld <= {vld[STAGES-2:0], pixel_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      ok1   <= in_range;
      sec1  <= sec_in;
      hmod1 <= MOD_W'(pixel.hue - sec_base);
      v1    <= pixel.brightness;
      prod1 <= PROD_W'(PCT_W'(PERCENT_FULL) - pixel.saturation) * PROD_W'(pixel.brightness);

      ok2   <= ok1;
      sec2  <= sec1;
      hmod2 <= hmod1;
      v2    <= v1;
      vmin2 <= div_prod[DIV100_SHIFT +: PCT_W];

      ok3      <= ok2;
      sec3     <= sec2;
      v60_3    <= X60_W'(v2) * X60_W'(SECTOR_DEG);
      vmin60_3 <= X60_W'(vmin2) * X60_W'(SECTOR_DEG);
      a60_3    <= X60_W'(diff2) * X60_W'(hmod2);

      ok4  <= ok3;
      sec4 <= sec3;
      ok5  <= ok4;
      sec5 <= sec4;

      rgb <= rgb_next;
    end
  end

  hsvp_scale u_scale_v   (.clk(clk), .ctl(ctl), .x60(x_cv),   .level(cv));
  hsvp_scale u_scale_min (.clk(clk), .ctl(ctl), .x60(x_cmin), .level(cmin));
  hsvp_scale u_scale_inc (.clk(clk), .ctl(ctl), .x60(x_cinc), .level(cinc));
  hsvp_scale u_scale_dec (.clk(clk), .ctl(ctl), .x60(x_cdec), .level(cdec));

  always_comb begin
    rgb_next.valid_res = ok5;
    case (sec5)
      SEC_0: begin
        rgb_next.red = cv;   rgb_next.green = cinc; rgb_next.blue = cmin;
      end
      SEC_1: begin
        rgb_next.red = cdec; rgb_next.green = cv;   rgb_next.blue = cmin;
      end
      SEC_2: begin
        rgb_next.red = cmin; rgb_next.green = cv;   rgb_next.blue = cinc;
      end
      SEC_3: begin
        rgb_next.red = cmin; rgb_next.green = cdec; rgb_next.blue = cv;
      end
      SEC_4: begin
        rgb_next.red = cinc; rgb_next.green = cmin; rgb_next.blue = cv;
      end
      default: begin
        // last sector
        rgb_next.red = cv;   rgb_next.green = cmin; rgb_next.blue = cdec;
      end
    endcase
    if (!ok5) begin
      rgb_next.red   = '0;
      rgb_next.green = '0;
      rgb_next.blue  = '0;
    end
  end

  `HSVP_ASSERT_IMP(a_invalid_is_black, clk, rst,
    rgb_valid && !rgb.valid_res,
    rgb.red == '0 && rgb.green == '0 && rgb.blue == '0)

  `HSVP_ASSERT_NXT(a_stall_freezes_pipe, clk, rst, !ctl.en, $stable(vld))

  `HSVP_ASSERT_NXT(a_transfer_enters_pipe, clk, rst, pixel_valid && pixel_ready, vld[0])

endmodule

FILE: hw/rtl/hsvp_scale.sv
// Two-stage scaler: level times 60 to an 8-bit channel, floor(x * 51 / 1200).
module hsvp_scale
  import hsvp_pkg::*;
(
  input  logic             clk,
  input  stage_ctl_t       ctl,
  input  logic [X60_W-1:0] x60,
  output logic [CH_W-1:0]  level
);

  logic [PRE_W-1:0]   pre_prod;
  logic [X60_W-1:0]   quart;
  logic [DIV25_W-1:0] div_prod;

  assign pre_prod = PRE_W'(x60) * PRE_W'(SCALE_MUL);
  assign div_prod = DIV25_W'(quart) * DIV25_W'(DIV25_MUL);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      quart <= pre_prod[SCALE_PRE +: X60_W];
      level <= div_prod[DIV25_SHIFT +: CH_W];
    end
  end

endmodule

FILE: tb/tb_hsv_percent_to_rgb8_unit.sv
// Self-checking testbench for the HSV percent to 8-bit RGB converter.
`timescale 1ns / 100ps

module tb_hsv_percent_to_rgb8_unit
  import hsvp_pkg::*;
();

  localparam int unsigned CLK_HALF       = 10;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned PIPE_LATENCY   = 6;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned LEVEL_TO_8_NUM = 51;    // 255/100 on levels kept times 60
  localparam int unsigned LEVEL_TO_8_DEN = 1200;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  logic   clk = 1'b0;
  logic   rst;
  logic   pixel_valid;
  logic   pixel_ready;
  pixel_t pixel;
  logic   rgb_valid;
  logic   rgb_ready;
  rgb_t   rgb;

  rgb_t        rgb_expected_q[$];
  int unsigned error_count;
  int unsigned pixels_sent;
  int unsigned out_of_range_sent;
  int unsigned results_checked;
  int unsigned cycle_count;

  // sender burst control and receiver stall control
  bit          sender_gaps;
  int unsigned burst_left;
  rx_mode_t    rx_mode;
  bit          hold_req;

  hsv_percent_to_rgb8_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .rgb_valid   (rgb_valid),
    .rgb_ready   (rgb_ready),
    .rgb         (rgb)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic logic [CH_W-1:0] level_to_byte(input int unsigned level60);
    return CH_W'((level60 * LEVEL_TO_8_NUM) / LEVEL_TO_8_DEN);
  endfunction

  function automatic rgb_t hsv_to_rgb_expected(input pixel_t p);
    int unsigned     h;
    int unsigned     s;
    int unsigned     v;
    int unsigned     floor_lvl;
    int unsigned     ramp60;
    logic [CH_W-1:0] ch_v;
    logic [CH_W-1:0] ch_min;
    logic [CH_W-1:0] ch_inc;
    logic [CH_W-1:0] ch_dec;
    sector_t         sec;
    rgb_t            res;
    res = '0;
    h = p.hue;
    s = p.saturation;
    v = p.brightness;
    if (h >= HUE_LIMIT || s > PERCENT_FULL || v > PERCENT_FULL) return res;
    floor_lvl = ((PERCENT_FULL - s) * v) / PERCENT_FULL;
    // ramp within the sector, kept times 60 so no fraction is lost
    ramp60 = (v - floor_lvl) * (h % SECTOR_DEG);
    ch_v   = level_to_byte(v * SECTOR_DEG);
    ch_min = level_to_byte(floor_lvl * SECTOR_DEG);
    ch_inc = level_to_byte(floor_lvl * SECTOR_DEG + ramp60);
    ch_dec = level_to_byte(v * SECTOR_DEG - ramp60);
    sec = sector_t'(h / SECTOR_DEG);
    res.valid_res = 1'b1;
    case (sec)
      SEC_0: begin res.red = ch_v;   res.green = ch_inc; res.blue = ch_min; end
      SEC_1: begin res.red = ch_dec; res.green = ch_v;   res.blue = ch_min; end
      SEC_2: begin res.red = ch_min; res.green = ch_v;   res.blue = ch_inc; end
      SEC_3: begin res.red = ch_min; res.green = ch_dec; res.blue = ch_v;   end
      SEC_4: begin res.red = ch_inc; res.green = ch_min; res.blue = ch_v;   end
      default: begin res.red = ch_v; res.green = ch_min; res.blue = ch_dec; end
    endcase
    return res;
  endfunction

  function automatic pixel_t make_pixel(input int unsigned h, input int unsigned s,
                                        input int unsigned v);
    pixel_t p;
    p.hue        = HUE_W'(h);
    p.saturation = PCT_W'(s);
    p.brightness = PCT_W'(v);
    return p;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer, or after a random gap.
  task automatic send_pixel(input pixel_t p);
    rgb_t expected;
    pixel       <= p;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    expected = hsv_to_rgb_expected(p);
    rgb_expected_q = {rgb_expected_q, expected};
    pixels_sent++;
    if (!expected.valid_res) out_of_range_sent++;
    @(negedge clk);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        pixel_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic stop_sending();
    pixel_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_corner_pixels();
    sender_gaps = 1'b1;
    rx_mode     = RX_RANDOM;
    // pure primaries and secondaries at each sector start, and the sector edges
    send_pixel(make_pixel(0, 100, 100));
    send_pixel(make_pixel(60, 100, 100));
    send_pixel(make_pixel(120, 100, 100));
    send_pixel(make_pixel(180, 100, 100));
    send_pixel(make_pixel(240, 100, 100));
    send_pixel(make_pixel(300, 100, 100));
    send_pixel(make_pixel(59, 100, 100));
    send_pixel(make_pixel(359, 100, 100));
    // black, grey and the full-scale level
    send_pixel(make_pixel(0, 0, 0));
    send_pixel(make_pixel(200, 0, 100));
    send_pixel(make_pixel(123, 37, 0));
    send_pixel(make_pixel(45, 50, 100));
    send_pixel(make_pixel(330, 1, 99));
    send_pixel(make_pixel(359, 100, 1));
    send_pixel(make_pixel(1, 99, 100));
    send_pixel(make_pixel(239, 73, 61));
    // out of range on each field, and on all at once
    send_pixel(make_pixel(360, 50, 50));
    send_pixel(make_pixel(511, 100, 100));
    send_pixel(make_pixel(100, 101, 50));
    send_pixel(make_pixel(100, 127, 50));
    send_pixel(make_pixel(100, 50, 101));
    send_pixel(make_pixel(100, 50, 127));
    send_pixel(make_pixel(511, 127, 127));
    stop_sending();
  endtask

  task automatic test_in_range_random(input int unsigned count);
    int unsigned s;
    int unsigned v;
    sender_gaps = 1'b1;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) rx_mode = RX_RANDOM;
      else if (i == 0) rx_mode = RX_PATTERN;
      // lean on saturation and value extremes now and then
      s = ($urandom_range(0, 7) == 0) ? 100 * $urandom_range(0, 1) : $urandom_range(0, 100);
      v = ($urandom_range(0, 7) == 0) ? 100 * $urandom_range(0, 1) : $urandom_range(0, 100);
      send_pixel(make_pixel($urandom_range(0, HUE_LIMIT - 1), s, v));
    end
    stop_sending();
  endtask

  task automatic test_full_field_random(input int unsigned count);
    sender_gaps = 1'b1;
    rx_mode     = RX_RANDOM;
    for (int unsigned i = 0; i < count; i++)
      send_pixel(make_pixel($urandom_range(0, (1 << HUE_W) - 1),
                            $urandom_range(0, (1 << PCT_W) - 1),
                            $urandom_range(0, (1 << PCT_W) - 1)));
    stop_sending();
  endtask

  task automatic test_output_hold(input int unsigned count);
    sender_gaps = 1'b0;
    rx_mode     = RX_ALWAYS;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    for (int unsigned i = 0; i < count; i++)
      send_pixel(make_pixel($urandom_range(0, HUE_LIMIT - 1), $urandom_range(0, 100),
                            $urandom_range(0, 100)));
    stop_sending();
  endtask

  task automatic test_streaming(input int unsigned count);
    sender_gaps = 1'b0;
    rx_mode     = RX_ALWAYS;
    for (int unsigned i = 0; i < count; i++)
      send_pixel(make_pixel($urandom_range(0, HUE_LIMIT - 1), $urandom_range(0, 100),
                            $urandom_range(0, 100)));
    stop_sending();
  endtask

  // Receiver: ready changes on the falling edge only.
  initial begin
    int unsigned hold_left;
    int unsigned rx_phase;
    hold_left = 0;
    rx_phase  = 0;
    rgb_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_phase++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rgb_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  rgb_ready <= 1'b1;
          RX_RANDOM:  rgb_ready <= ($urandom_range(0, 99) < 70);
          RX_PATTERN: rgb_ready <= (rx_phase % 7 != 0) && (rx_phase % 7 != 3);
          default:    rgb_ready <= 1'b1;
        endcase
      end
    end
  end

  // Check every rgb transfer against the oldest prediction.
  always @(posedge clk) begin
    rgb_t expected;
    if (!rst && rgb_valid && rgb_ready) begin
      if (rgb_expected_q.size() == 0) begin
        $error("rgb transfer with no pixel outstanding: %h", rgb);
        error_count++;
      end else begin
        expected = rgb_expected_q.pop_front();
        results_checked++;
        if (rgb.valid_res !== expected.valid_res) begin
          $error("valid_res: expected %0d, got %0d", expected.valid_res, rgb.valid_res);
          error_count++;
        end
        if (rgb.red !== expected.red) begin
          $error("red: expected %0d, got %0d", expected.red, rgb.red);
          error_count++;
        end
        if (rgb.green !== expected.green) begin
          $error("green: expected %0d, got %0d", expected.green, rgb.green);
          error_count++;
        end
        if (rgb.blue !== expected.blue) begin
          $error("blue: expected %0d, got %0d", expected.blue, rgb.blue);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             rgb_expected_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    pixel_valid       = 1'b0;
    pixel             = '0;
    error_count       = 0;
    pixels_sent       = 0;
    out_of_range_sent = 0;
    results_checked   = 0;
    cycle_count       = 0;
    sender_gaps       = 1'b0;
    burst_left        = 0;
    rx_mode           = RX_ALWAYS;
    hold_req          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_corner_pixels();
    test_in_range_random(350);
    test_full_field_random(150);
    test_output_hold(60);
    test_streaming(60);

    rx_mode = RX_ALWAYS;
    while (rgb_expected_q.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("Converted %0d pixels (%0d out of range), %0d results checked,", pixels_sent,
             out_of_range_sent, results_checked);
    $display("under bursty, stalled, held-off and full-rate streaming traffic.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
